>>> rtl/rid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rid_pkg
// Shared types and constants of the resistor ID reader: digit resistor table,
// class codes, event codes, register map and the per-lane result record.
// ----------------------------------------------------------------------------
package rid_pkg;

   localparam int RID_LANES  = 4;   // check, ones, tens, hundreds
   localparam int RID_DIGITS = 10;

   localparam int LANE_CHECK    = 0;
   localparam int LANE_ONES     = 1;
   localparam int LANE_TENS     = 2;
   localparam int LANE_HUNDREDS = 3;

   localparam int LEVEL_W = 12;
   localparam int REF_W   = 16;
   localparam int DIGIT_W = 4;
   localparam int ID_W    = 10;
   localparam int COUNT_W = 8;
   localparam int KIND_W  = 2;

   // Defaults of the build-time analog parameters
   localparam int RID_PULLUP_OHMS = 47000;
   localparam int RID_FULL_SCALE  = 4095;
   localparam int RID_SCALE_NUM   = 1;
   localparam int RID_SCALE_DEN   = 1;

   // Resistor value for each digit, in ohms
   localparam int unsigned RID_DIGIT_OHMS [RID_DIGITS] = '{
      1020, 18300, 39300, 68300, 114000,
      164000, 244000, 364000, 564000, 914000
   };

   typedef enum logic [KIND_W-1:0] {
      KIND_INVALID = 2'd0,
      KIND_REMOVED = 2'd1,
      KIND_CONTACT = 2'd2,
      KIND_PRESENT = 2'd3
   } kind_type;

   localparam logic [KIND_W-1:0] EVENT_IDLE    = 2'd0;
   localparam logic [KIND_W-1:0] EVENT_REMOVED = 2'd1;
   localparam logic [KIND_W-1:0] EVENT_CONTACT = 2'd2;
   localparam logic [KIND_W-1:0] EVENT_PRESENT = 2'd3;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_ENABLE    = 2'd0,
      REG_OPEN_THR  = 2'd1,
      REG_TOLERANCE = 2'd2,
      REG_STABLE    = 2'd3
   } reg_index_type;

   localparam logic [LEVEL_W-1:0] RESET_OPEN_THR  = 12'd3995;
   localparam logic [LEVEL_W-1:0] RESET_TOLERANCE = 12'd150;
   localparam logic [COUNT_W-1:0] RESET_STABLE    = 8'd3;

   typedef struct packed {
      logic               open;   // level at or above open threshold
      logic               hit;    // nearest reference within tolerance
      logic [DIGIT_W-1:0] digit;  // nearest digit, 0..9
   } lane_result_type;

endpackage
`default_nettype wire

>>> rtl/rid_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rid_lane
// One pad lane: open test and nearest-digit match against ten reference
// levels, all distances compared in parallel. Result is registered.
// ----------------------------------------------------------------------------
module rid_lane
   import rid_pkg::*;
#(
   parameter int PULLUP_OHMS = RID_PULLUP_OHMS,
   parameter int FULL_SCALE  = RID_FULL_SCALE,
   parameter int SCALE_NUM   = RID_SCALE_NUM,
   parameter int SCALE_DEN   = RID_SCALE_DEN
) (
   input  wire logic                 clock,
   input  wire logic                 load,
   input  wire logic [LEVEL_W-1:0]   level,
   input  wire logic [LEVEL_W-1:0]   open_threshold,
   input  wire logic [LEVEL_W-1:0]   match_tolerance,
   output lane_result_type           result
);

   logic [REF_W-1:0]      gap [RID_DIGITS];
   logic [RID_DIGITS-1:0] win;
   logic [REF_W-1:0]      best_dist;
   logic [DIGIT_W-1:0]    near_digit;
   lane_result_type       result_in;
   lane_result_type       result_ff;

   for (genvar d = 0; d < RID_DIGITS; d++) begin : g_ref
      localparam logic [63:0] OHMS   = 64'(RID_DIGIT_OHMS[d]);
      localparam logic [63:0] DEN    = OHMS + 64'(PULLUP_OHMS);
      localparam logic [63:0] IDEAL  = (64'(FULL_SCALE) * OHMS + DEN / 2) / DEN;
      localparam logic [63:0] SCALED =
         (IDEAL * 64'(SCALE_NUM) + 64'(SCALE_DEN / 2)) / 64'(SCALE_DEN);
      localparam logic [REF_W-1:0] REF_LEVEL = SCALED[REF_W-1:0];

      logic [REF_W-1:0] lvl;
      assign lvl    = {{(REF_W-LEVEL_W){1'b0}}, level};
      assign gap[d] = (lvl > REF_LEVEL) ? (lvl - REF_LEVEL) : (REF_LEVEL - lvl);
   end

   // Digit d wins when strictly closer than every lower digit and no farther
   // than every higher one: ties go to the lower digit, exactly one winner.
   always_comb begin
      for (int d = 0; d < RID_DIGITS; d++) begin
         win[d] = 1'b1;
         for (int j = 0; j < RID_DIGITS; j++) begin
            if (j < d && !(gap[d] < gap[j])) win[d] = 1'b0;
            if (j > d && !(gap[d] <= gap[j])) win[d] = 1'b0;
         end
      end
   end

   always_comb begin
      best_dist  = '0;
      near_digit = '0;
      for (int d = 0; d < RID_DIGITS; d++) begin
         if (win[d]) begin
            best_dist  = best_dist | gap[d];
            near_digit = near_digit | DIGIT_W'(d);
         end
      end
   end

   always_comb begin
      result_in.open  = (level >= open_threshold);
      result_in.hit   = (best_dist <= {{(REF_W-LEVEL_W){1'b0}}, match_tolerance});
      result_in.digit = near_digit;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule
`default_nettype wire

>>> rtl/rid_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rid_merge
// Combines the four lane results into a poll class, runs the repeat filter
// and holds the event output register.
// ----------------------------------------------------------------------------
module rid_merge
   import rid_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 s1_valid,
   input  lane_result_type           lanes [RID_LANES],
   input  wire logic                 read_failed,
   input  wire logic                 reader_enabled,
   input  wire logic [COUNT_W-1:0]   stable_polls,
   output logic                      s1_go,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [KIND_W-1:0]         rsp_event_kind,
   output logic [ID_W-1:0]           rsp_figure_id
);

   kind_type              cand_kind_ff, cand_kind_in;
   logic [ID_W-1:0]       cand_id_ff, cand_id_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   kind_type              shown_kind_ff, shown_kind_in;
   logic [ID_W-1:0]       shown_id_ff, shown_id_in;
   logic                  out_valid_ff, out_valid_in;
   logic [KIND_W-1:0]     out_kind_ff, out_kind_in;
   logic [ID_W-1:0]       out_id_ff, out_id_in;

   kind_type              kind;
   logic [ID_W-1:0]       id;
   logic                  every_open, none_open, all_hit;
   logic [4:0]            digit_sum;
   logic [DIGIT_W-1:0]    sum_mod;
   logic                  same_cand, same_shown;
   logic [COUNT_W-1:0]    count_bump;
   logic                  emit;
   logic                  out_hold;

   always_comb begin
      every_open = 1'b1;
      none_open  = 1'b1;
      all_hit    = 1'b1;
      for (int i = 0; i < RID_LANES; i++) begin
         every_open = every_open & lanes[i].open;
         none_open  = none_open & !lanes[i].open;
         all_hit    = all_hit & lanes[i].hit;
      end
   end

   always_comb begin
      digit_sum = 5'(lanes[LANE_ONES].digit) + 5'(lanes[LANE_TENS].digit)
                + 5'(lanes[LANE_HUNDREDS].digit);
      if (digit_sum >= 5'd20) begin
         sum_mod = DIGIT_W'(digit_sum - 5'd20);
      end else if (digit_sum >= 5'd10) begin
         sum_mod = DIGIT_W'(digit_sum - 5'd10);
      end else begin
         sum_mod = DIGIT_W'(digit_sum);
      end
   end

   always_comb begin
      kind = KIND_CONTACT;
      id   = '0;
      if (read_failed) begin
         kind = KIND_CONTACT;
      end else if (every_open) begin
         kind = KIND_REMOVED;
      end else if (none_open && all_hit && lanes[LANE_CHECK].digit == sum_mod) begin
         kind = KIND_PRESENT;
         id   = ID_W'(lanes[LANE_HUNDREDS].digit) * ID_W'(100)
              + ID_W'(lanes[LANE_TENS].digit) * ID_W'(10)
              + ID_W'(lanes[LANE_ONES].digit);
      end
   end

   assign same_cand  = (kind == cand_kind_ff) && (kind != KIND_PRESENT || id == cand_id_ff);
   assign same_shown = (kind == shown_kind_ff)
                       && (kind != KIND_PRESENT || id == shown_id_ff);
   assign count_bump = (count_ff < stable_polls) ? count_ff + 8'd1 : count_ff;
   assign emit       = reader_enabled && same_cand && (count_bump >= stable_polls)
                       && !same_shown;

   // Merge stage only waits when it has an event and the output is still held
   assign out_hold = out_valid_ff && rsp_stall;
   assign s1_go    = s1_valid && (!out_hold || !emit);

   always_comb begin
      cand_kind_in  = cand_kind_ff;
      cand_id_in    = cand_id_ff;
      count_in      = count_ff;
      shown_kind_in = shown_kind_ff;
      shown_id_in   = shown_id_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_kind_in   = out_kind_ff;
      out_id_in     = out_id_ff;
      if (s1_go && reader_enabled) begin
         if (!same_cand) begin
            cand_kind_in = kind;
            cand_id_in   = id;
            count_in     = 8'd1;
         end else begin
            count_in = count_bump;
            if (emit) begin
               shown_kind_in = kind;
               shown_id_in   = id;
               out_valid_in  = 1'b1;
               out_kind_in   = (shown_kind_ff == KIND_INVALID && kind == KIND_REMOVED)
                               ? EVENT_IDLE : KIND_W'(kind);
               out_id_in     = (kind == KIND_PRESENT) ? id : '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_kind_ff  <= KIND_INVALID;
         cand_id_ff    <= '0;
         count_ff      <= '0;
         shown_kind_ff <= KIND_INVALID;
         shown_id_ff   <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         cand_kind_ff  <= cand_kind_in;
         cand_id_ff    <= cand_id_in;
         count_ff      <= count_in;
         shown_kind_ff <= shown_kind_in;
         shown_id_ff   <= shown_id_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff <= out_kind_in;
      out_id_ff   <= out_id_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_event_kind = out_kind_ff;
   assign rsp_figure_id  = out_id_ff;

endmodule
`default_nettype wire

>>> rtl/resistor_id_reader_debounce_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// resistor_id_reader_debounce_top
// Resistor ID reader: classifies each poll of four pad levels, filters it
// through a repeat count and reports changes as events.
// ----------------------------------------------------------------------------
// Takes one poll request per clock while req_stall is low. Four lanes, one per
// pad, match the level against the ten digit reference levels in parallel and
// register the result; the merge stage then classes the poll, runs the repeat
// filter and loads the event register, which drives the response. While an
// event sits stalled on the output, one further request is still taken into
// the lane stage; more wait only if that poll would also raise an event.
// A poll that raises no event never holds the lane stage. Registers (byte
// address 4*i): 0 reader enable, 1 open threshold, 2 match tolerance, 3 stable
// poll count; write them only while no poll is in flight.
module resistor_id_reader_debounce_top
   import rid_pkg::*;
#(
   parameter int PULLUP_OHMS = RID_PULLUP_OHMS,
   parameter int FULL_SCALE  = RID_FULL_SCALE,
   parameter int SCALE_NUM   = RID_SCALE_NUM,
   parameter int SCALE_DEN   = RID_SCALE_DEN
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [LEVEL_W-1:0]      req_check_level,
   input  wire logic [LEVEL_W-1:0]      req_ones_level,
   input  wire logic [LEVEL_W-1:0]      req_tens_level,
   input  wire logic [LEVEL_W-1:0]      req_hundreds_level,
   input  wire logic                    req_read_failed,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [KIND_W-1:0]            rsp_event_kind,
   output logic [ID_W-1:0]              rsp_figure_id,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]        csr_prdata,
   output logic                         csr_pready
);

   logic                 enable_ff, enable_in;
   logic [LEVEL_W-1:0]   open_thr_ff, open_thr_in;
   logic [LEVEL_W-1:0]   tolerance_ff, tolerance_in;
   logic [COUNT_W-1:0]   stable_ff, stable_in;
   logic                 s1_valid_ff, s1_valid_in;
   logic                 read_failed_ff;
   logic                 csr_write;
   reg_index_type        csr_index;
   logic                 accept;
   logic                 s1_go;
   logic [LEVEL_W-1:0]   lane_level [RID_LANES];
   lane_result_type      lane_result [RID_LANES];

   // ---------------- configuration registers ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      enable_in    = enable_ff;
      open_thr_in  = open_thr_ff;
      tolerance_in = tolerance_ff;
      stable_in    = stable_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_ENABLE:    enable_in    = csr_pwdata[0];
            REG_OPEN_THR:  open_thr_in  = csr_pwdata[LEVEL_W-1:0];
            REG_TOLERANCE: tolerance_in = csr_pwdata[LEVEL_W-1:0];
            REG_STABLE:    stable_in    = csr_pwdata[COUNT_W-1:0];
            default:       enable_in    = enable_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_ENABLE:    csr_prdata = CSR_DATA_W'(enable_ff);
         REG_OPEN_THR:  csr_prdata = CSR_DATA_W'(open_thr_ff);
         REG_TOLERANCE: csr_prdata = CSR_DATA_W'(tolerance_ff);
         REG_STABLE:    csr_prdata = CSR_DATA_W'(stable_ff);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b1;
         open_thr_ff  <= RESET_OPEN_THR;
         tolerance_ff <= RESET_TOLERANCE;
         stable_ff    <= RESET_STABLE;
      end else begin
         enable_ff    <= enable_in;
         open_thr_ff  <= open_thr_in;
         tolerance_ff <= tolerance_in;
         stable_ff    <= stable_in;
      end
   end

   // ---------------- lane stage ----------------
   assign req_stall   = s1_valid_ff && !s1_go;
   assign accept      = req_valid && !req_stall;
   assign s1_valid_in = accept || (s1_valid_ff && !s1_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         read_failed_ff <= req_read_failed;
      end
   end

   assign lane_level[LANE_CHECK]    = req_check_level;
   assign lane_level[LANE_ONES]     = req_ones_level;
   assign lane_level[LANE_TENS]     = req_tens_level;
   assign lane_level[LANE_HUNDREDS] = req_hundreds_level;

   for (genvar i = 0; i < RID_LANES; i++) begin : g_lane
      rid_lane #(
         .PULLUP_OHMS (PULLUP_OHMS),
         .FULL_SCALE  (FULL_SCALE),
         .SCALE_NUM   (SCALE_NUM),
         .SCALE_DEN   (SCALE_DEN)
      ) u_lane (
         .clock           (clock),
         .load            (accept),
         .level           (lane_level[i]),
         .open_threshold  (open_thr_ff),
         .match_tolerance (tolerance_ff),
         .result          (lane_result[i])
      );
   end

   // ---------------- merge, debounce and output ----------------
   rid_merge u_merge (
      .clock          (clock),
      .reset          (reset),
      .s1_valid       (s1_valid_ff),
      .lanes          (lane_result),
      .read_failed    (read_failed_ff),
      .reader_enabled (enable_ff),
      .stable_polls   (stable_ff),
      .s1_go          (s1_go),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_event_kind (rsp_event_kind),
      .rsp_figure_id  (rsp_figure_id)
   );

   // ---------------- assertions ----------------
   a_id_only_present: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_kind != EVENT_PRESENT) |-> (rsp_figure_id == '0))
      else $error("figure id nonzero on a non-present event");

   a_lane_item_kept: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |=> s1_valid_ff)
      else $error("lane stage request dropped while merge stage waited");

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_valid && !s1_valid_ff)
      else $error("pipeline not empty after reset");

   a_present_id_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_figure_id <= ID_W'(999)))
      else $error("figure id out of range");

endmodule
`default_nettype wire

>>> sim/resistor_id_reader_debounce_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resistor_id_reader_debounce_top_test
// Self-checking bench for the resistor ID reader. Polls are classed by a
// local predictor (digit matching, checksum, open pads, repeat filter), and
// every event from the block is compared in order with the predicted one.
// Directed polls cover each class and the register extremes; random runs of
// repeated classes follow under random gaps and output stalls.
// ----------------------------------------------------------------------------
module resistor_id_reader_debounce_top_test;
   import rid_pkg::*;

   localparam int NO_DIGIT     = RID_DIGITS;
   localparam int PRINT_LIMIT  = 100;
   localparam int DRAIN_CYCLES = 10000;

   typedef struct packed {
      logic [LEVEL_W-1:0] check_level;
      logic [LEVEL_W-1:0] ones_level;
      logic [LEVEL_W-1:0] tens_level;
      logic [LEVEL_W-1:0] hundreds_level;
      logic               read_failed;
   } poll_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   figure_id;
   } report_type;

   typedef enum int {
      FAULT_READ,
      FAULT_PARTLY_OPEN,
      FAULT_CHECKSUM,
      FAULT_FAR_LEVEL
   } fault_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [LEVEL_W-1:0]    req_check_level = '0;
   logic [LEVEL_W-1:0]    req_ones_level = '0;
   logic [LEVEL_W-1:0]    req_tens_level = '0;
   logic [LEVEL_W-1:0]    req_hundreds_level = '0;
   logic                  req_read_failed = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [KIND_W-1:0]     rsp_event_kind;
   logic [ID_W-1:0]       rsp_figure_id;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // register shadow
   logic                  cfg_enable;
   logic [LEVEL_W-1:0]    cfg_open_thr;
   logic [LEVEL_W-1:0]    cfg_tolerance;
   logic [COUNT_W-1:0]    cfg_stable;

   // debounce state of the predictor
   kind_type              held_kind;
   logic [ID_W-1:0]       held_id;
   logic [COUNT_W-1:0]    held_repeats;
   kind_type              last_kind;
   logic [ID_W-1:0]       last_id;

   int                    digit_ref [RID_DIGITS];
   logic [LEVEL_W-1:0]    far_level;
   logic [LEVEL_W-1:0]    tie_level;
   report_type            pending_reports [$];
   int                    mismatch_count = 0;
   int                    send_idle_pct = 0;
   int                    recv_idle_pct = 0;
   int                    hold_cycles = 0;

   resistor_id_reader_debounce_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_check_level    (req_check_level),
      .req_ones_level     (req_ones_level),
      .req_tens_level     (req_tens_level),
      .req_hundreds_level (req_hundreds_level),
      .req_read_failed    (req_read_failed),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_figure_id      (rsp_figure_id),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic int reference_level(input longint unsigned ohms);
      longint unsigned span;
      longint unsigned ideal;
      span  = ohms + RID_PULLUP_OHMS;
      ideal = (RID_FULL_SCALE * ohms + span / 2) / span;
      return int'(((ideal * RID_SCALE_NUM + RID_SCALE_DEN / 2) / RID_SCALE_DEN) & 16'hFFFF);
   endfunction

   // lower digit wins on equal distance
   function automatic int nearest_digit(input logic [LEVEL_W-1:0] level);
      int lv;
      int best;
      int best_dist;
      int gap;
      lv = level;
      best = NO_DIGIT;
      best_dist = 32'h7FFF_FFFF;
      for (int d = 0; d < RID_DIGITS; d++) begin
         gap = (lv > digit_ref[d]) ? lv - digit_ref[d] : digit_ref[d] - lv;
         if (gap < best_dist) begin
            best_dist = gap;
            best = d;
         end
      end
      return (best_dist > int'(cfg_tolerance)) ? NO_DIGIT : best;
   endfunction

   function automatic void classify_poll(input poll_type p, output kind_type kind,
                                         output logic [ID_W-1:0] id);
      logic [LEVEL_W-1:0] lv [RID_LANES];
      int dig [RID_LANES];
      int opens;
      lv[LANE_CHECK]    = p.check_level;
      lv[LANE_ONES]     = p.ones_level;
      lv[LANE_TENS]     = p.tens_level;
      lv[LANE_HUNDREDS] = p.hundreds_level;
      opens = 0;
      kind = KIND_CONTACT;
      id = '0;
      foreach (lv[i]) begin
         if (lv[i] >= cfg_open_thr) opens++;
      end
      if (p.read_failed) begin
         kind = KIND_CONTACT;
      end else if (opens == RID_LANES) begin
         kind = KIND_REMOVED;
      end else if (opens == 0) begin
         foreach (lv[i]) dig[i] = nearest_digit(lv[i]);
         if (dig[LANE_CHECK] < NO_DIGIT && dig[LANE_ONES] < NO_DIGIT &&
             dig[LANE_TENS] < NO_DIGIT && dig[LANE_HUNDREDS] < NO_DIGIT &&
             dig[LANE_CHECK] == (dig[LANE_ONES] + dig[LANE_TENS] + dig[LANE_HUNDREDS]) % 10)
         begin
            kind = KIND_PRESENT;
            id = ID_W'(dig[LANE_HUNDREDS] * 100 + dig[LANE_TENS] * 10 + dig[LANE_ONES]);
         end
      end
   endfunction

   function automatic bit same_class(input kind_type ka, input logic [ID_W-1:0] ia,
                                     input kind_type kb, input logic [ID_W-1:0] ib);
      return ka == kb && (ka != KIND_PRESENT || ia == ib);
   endfunction

   function automatic bit predict_report(input poll_type p, output report_type r);
      kind_type        kind;
      logic [ID_W-1:0] id;
      r = '0;
      if (!cfg_enable) return 1'b0;
      classify_poll(p, kind, id);
      if (!same_class(kind, id, held_kind, held_id)) begin
         held_kind = kind;
         held_id = id;
         held_repeats = 8'd1;
         return 1'b0;
      end
      if (held_repeats < cfg_stable) held_repeats++;
      if (held_repeats >= cfg_stable && !same_class(kind, id, last_kind, last_id)) begin
         r.kind = (last_kind == KIND_INVALID && kind == KIND_REMOVED) ? EVENT_IDLE : kind;
         r.figure_id = (kind == KIND_PRESENT) ? id : '0;
         last_kind = kind;
         last_id = id;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // ------------------------------------------------------------------------
   // Poll builders
   // ------------------------------------------------------------------------
   function automatic logic [LEVEL_W-1:0] level_near(input int center, input int jitter);
      int v;
      v = center + int'($urandom_range(2 * jitter)) - jitter;
      if (v < 0) v = 0;
      if (v > RID_FULL_SCALE) v = RID_FULL_SCALE;
      return LEVEL_W'(v);
   endfunction

   function automatic poll_type figure_poll(input int fig, input int jitter);
      poll_type p;
      int o;
      int t;
      int h;
      o = fig % 10;
      t = (fig / 10) % 10;
      h = fig / 100;
      p.ones_level     = level_near(digit_ref[o], jitter);
      p.tens_level     = level_near(digit_ref[t], jitter);
      p.hundreds_level = level_near(digit_ref[h], jitter);
      p.check_level    = level_near(digit_ref[(o + t + h) % 10], jitter);
      p.read_failed    = 1'b0;
      return p;
   endfunction

   function automatic poll_type flat_poll(input logic [LEVEL_W-1:0] level);
      poll_type p;
      p.check_level = level;
      p.ones_level = level;
      p.tens_level = level;
      p.hundreds_level = level;
      p.read_failed = 1'b0;
      return p;
   endfunction

   function automatic poll_type set_lane(input poll_type p, input int lane,
                                         input logic [LEVEL_W-1:0] level);
      case (lane)
         LANE_CHECK:    p.check_level = level;
         LANE_ONES:     p.ones_level = level;
         LANE_TENS:     p.tens_level = level;
         default:       p.hundreds_level = level;
      endcase
      return p;
   endfunction

   function automatic poll_type open_poll();
      poll_type p;
      p.check_level    = LEVEL_W'($urandom_range(RID_FULL_SCALE, cfg_open_thr));
      p.ones_level     = LEVEL_W'($urandom_range(RID_FULL_SCALE, cfg_open_thr));
      p.tens_level     = LEVEL_W'($urandom_range(RID_FULL_SCALE, cfg_open_thr));
      p.hundreds_level = LEVEL_W'($urandom_range(RID_FULL_SCALE, cfg_open_thr));
      p.read_failed    = 1'b0;
      return p;
   endfunction

   function automatic poll_type noise_poll();
      poll_type p;
      p.check_level    = LEVEL_W'($urandom_range(RID_FULL_SCALE));
      p.ones_level     = LEVEL_W'($urandom_range(RID_FULL_SCALE));
      p.tens_level     = LEVEL_W'($urandom_range(RID_FULL_SCALE));
      p.hundreds_level = LEVEL_W'($urandom_range(RID_FULL_SCALE));
      p.read_failed    = 1'($urandom_range(1));
      return p;
   endfunction

   function automatic poll_type contact_poll();
      poll_type  p;
      fault_type fault;
      int        fig;
      int        sum;
      int        lane;
      fig = $urandom_range(999);
      sum = fig % 10 + (fig / 10) % 10 + fig / 100;
      lane = $urandom_range(RID_LANES - 1);
      fault = fault_type'($urandom_range(FAULT_FAR_LEVEL));
      p = figure_poll(fig, 30);
      case (fault)
         FAULT_READ:        p.read_failed = 1'b1;
         FAULT_PARTLY_OPEN: p = set_lane(p, lane,
                                         LEVEL_W'($urandom_range(RID_FULL_SCALE, cfg_open_thr)));
         FAULT_CHECKSUM:    p.check_level = level_near(digit_ref[(sum + 1 + $urandom_range(8)) % 10], 30);
         default:           p = set_lane(p, lane, far_level);
      endcase
      return p;
   endfunction

   // ------------------------------------------------------------------------
   // Bus and handshake tasks
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic send_poll(input poll_type p);
      report_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_check_level    <= p.check_level;
      req_ones_level     <= p.ones_level;
      req_tens_level     <= p.tens_level;
      req_hundreds_level <= p.hundreds_level;
      req_read_failed    <= p.read_failed;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (predict_report(p, r)) pending_reports.push_back(r);
   endtask

   task automatic send_twice(input poll_type p);
      send_poll(p);
      send_poll(p);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_ENABLE:    cfg_enable = value[0];
         REG_OPEN_THR:  cfg_open_thr = value[LEVEL_W-1:0];
         REG_TOLERANCE: cfg_tolerance = value[LEVEL_W-1:0];
         default:       cfg_stable = value[COUNT_W-1:0];
      endcase
      @(posedge clock);
   endtask

   task automatic check_register(input reg_index_type idx);
      logic [CSR_DATA_W-1:0] value;
      logic [CSR_DATA_W-1:0] want;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      value = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_ENABLE:    want = CSR_DATA_W'(cfg_enable);
         REG_OPEN_THR:  want = CSR_DATA_W'(cfg_open_thr);
         REG_TOLERANCE: want = CSR_DATA_W'(cfg_tolerance);
         default:       want = CSR_DATA_W'(cfg_stable);
      endcase
      if (value !== want)
         report_mismatch($sformatf("register %s read %0h, expected %0h", idx.name(), value, want));
      @(posedge clock);
   endtask

   // registers may only change once nothing is in flight
   task automatic apply_settings(input logic en, input logic [LEVEL_W-1:0] thr,
                                 input logic [LEVEL_W-1:0] tol, input logic [COUNT_W-1:0] stable);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write(REG_ENABLE, CSR_DATA_W'(en));
      csr_write(REG_OPEN_THR, CSR_DATA_W'(thr));
      csr_write(REG_TOLERANCE, CSR_DATA_W'(tol));
      csr_write(REG_STABLE, CSR_DATA_W'(stable));
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_register_access();
      for (int i = 0; i < 4; i++) check_register(reg_index_type'(i));
      // upper bits beyond each register's width are dropped
      csr_write(REG_ENABLE, 32'hFFFF_FFFE);
      csr_write(REG_OPEN_THR, 32'h0000_1ABC);
      csr_write(REG_TOLERANCE, 32'hFFFF_F555);
      csr_write(REG_STABLE, 32'h0000_01C3);
      for (int i = 0; i < 4; i++) check_register(reg_index_type'(i));
      apply_settings(1'b1, RESET_OPEN_THR, RESET_TOLERANCE, RESET_STABLE);
      for (int i = 0; i < 4; i++) check_register(reg_index_type'(i));
   endtask

   task automatic test_directed_classes();
      poll_type p;
      apply_settings(1'b1, RESET_OPEN_THR, RESET_TOLERANCE, 8'd1);
      send_twice(flat_poll(12'hFFF));          // first removal gives the idle event
      send_twice(flat_poll(12'h000));          // all pads at zero read as figure 000
      send_twice(figure_poll(999, 0));
      send_poll(figure_poll(999, 30));         // already shown: silent
      p = figure_poll(999, 0);
      p.read_failed = 1'b1;
      send_twice(p);
      send_twice(flat_poll(12'hFFF));          // later removal is a plain removed event
      send_twice(set_lane(figure_poll(456, 0), LANE_TENS, 12'hFFF));
      send_twice(figure_poll(456, 0));
      send_twice(set_lane(figure_poll(456, 0), LANE_CHECK, LEVEL_W'(digit_ref[6])));
      send_twice(figure_poll(120, 0));
      send_twice(set_lane(figure_poll(120, 0), LANE_ONES, far_level));
   endtask

   task automatic test_setting_extremes();
      apply_settings(1'b1, 12'hFFF, 12'hFFF, 8'd1);
      send_twice(set_lane(figure_poll(3, 0), LANE_ONES, tie_level));
      send_twice(flat_poll(12'hFFF));
      send_twice(flat_poll(12'hFFE));
      apply_settings(1'b1, RESET_OPEN_THR, 12'd0, 8'd1);
      send_twice(figure_poll(258, 0));
      send_twice(figure_poll(258, 5));
      apply_settings(1'b1, 12'd0, RESET_TOLERANCE, 8'd1);
      send_twice(figure_poll(640, 10));        // every pad counts as open
      // zero repeat count: any repeat that differs from the shown class reports
      apply_settings(1'b1, RESET_OPEN_THR, RESET_TOLERANCE, 8'd0);
      send_twice(figure_poll(777, 20));
      send_poll(flat_poll(12'hFFF));
      send_poll(flat_poll(12'hFFF));
      send_poll(figure_poll(777, 20));
      apply_settings(1'b0, RESET_OPEN_THR, RESET_TOLERANCE, RESET_STABLE);
      repeat (4) send_poll(noise_poll());
      send_twice(figure_poll(31, 0));
   endtask

   // long output hold while requests keep coming, so the input stalls
   task automatic test_output_backpressure();
      int saved_pct;
      apply_settings(1'b1, RESET_OPEN_THR, RESET_TOLERANCE, 8'd1);
      saved_pct = send_idle_pct;
      send_idle_pct = 0;
      hold_cycles = 300;
      repeat (30) send_twice(figure_poll($urandom_range(999), 30));
      send_idle_pct = saved_pct;
   endtask

   task automatic test_slow_debounce();
      int fig;
      apply_settings(1'b1, RESET_OPEN_THR, RESET_TOLERANCE, 8'd255);
      fig = $urandom_range(999);
      repeat (258) send_poll(figure_poll(fig, 30));
   endtask

   task automatic test_random_polls(input logic [LEVEL_W-1:0] thr, input logic [LEVEL_W-1:0] tol,
                                    input logic [COUNT_W-1:0] stable, input int item_count);
      poll_type p;
      int sent;
      int pick;
      int run_len;
      int fig;
      apply_settings(1'b1, thr, tol, stable);
      sent = 0;
      while (sent < item_count) begin
         pick = $urandom_range(99);
         run_len = $urandom_range(((cfg_stable < 6) ? int'(cfg_stable) : 6) + 2, 1);
         fig = $urandom_range(999);
         repeat (run_len) begin
            if (pick < 45) p = figure_poll(fig, 30);
            else if (pick < 60) p = open_poll();
            else if (pick < 80) p = contact_poll();
            else p = noise_poll();
            // occasionally break a clean run
            if (pick < 60 && $urandom_range(19) == 0) p = noise_poll();
            send_poll(p);
            sent++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Output side
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            report_mismatch($sformatf("unexpected event kind %0d id %0d",
                                      rsp_event_kind, rsp_figure_id));
         end else begin
            want = pending_reports.pop_front();
            if (rsp_event_kind !== want.kind)
               report_mismatch($sformatf("event kind %0d, expected %0d",
                                         rsp_event_kind, want.kind));
            if (rsp_figure_id !== want.figure_id)
               report_mismatch($sformatf("figure id %0d, expected %0d",
                                         rsp_figure_id, want.figure_id));
         end
      end
   end

   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin : run_tests
      int drain_wait;
      cfg_enable    = 1'b1;
      cfg_open_thr  = RESET_OPEN_THR;
      cfg_tolerance = RESET_TOLERANCE;
      cfg_stable    = RESET_STABLE;
      held_kind     = KIND_INVALID;
      held_id       = '0;
      held_repeats  = '0;
      last_kind     = KIND_INVALID;
      last_id       = '0;
      for (int d = 0; d < RID_DIGITS; d++) digit_ref[d] = reference_level(RID_DIGIT_OHMS[d]);
      far_level = LEVEL_W'((digit_ref[0] + digit_ref[1]) / 2);
      tie_level = LEVEL_W'((digit_ref[3] + digit_ref[4]) / 2);   // equidistant from three and four

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 37;
      recv_idle_pct = 75;
      test_register_access();
      test_directed_classes();
      test_setting_extremes();
      test_output_backpressure();
      test_slow_debounce();
      test_random_polls(RESET_OPEN_THR, RESET_TOLERANCE, 8'd2, 350);
      send_idle_pct = 75;
      recv_idle_pct = 37;
      test_random_polls(12'hFFF, 12'hFFF, 8'd1, 350);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_polls(LEVEL_W'($urandom_range(4095, 3000)), LEVEL_W'($urandom_range(300)),
                        RESET_STABLE, 350);

      req_valid <= 1'b0;
      drain_wait = 0;
      while (pending_reports.size() != 0 && drain_wait < DRAIN_CYCLES) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (8) @(posedge clock);
      if (pending_reports.size() != 0)
         report_mismatch($sformatf("%0d events never arrived", pending_reports.size()));
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/rid_pkg.sv
rtl/rid_lane.sv
rtl/rid_merge.sv
rtl/resistor_id_reader_debounce_top.sv
sim/resistor_id_reader_debounce_top_test.sv
